### rtl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
// Used by the controller, the datapath and the top level.
`default_nettype none
package mlfq_pkg;

    localparam int MaxLevels = 8;
    localparam int MaxProcs  = 64;
    localparam int LvlW      = 3;
    localparam int PidW      = 6;
    localparam int CntW      = 7;
    localparam int CycW      = 31;
    localparam int InDataW   = 40;
    localparam int OutDataW  = 16;

    localparam logic [1:0] ACT_ADMIT  = 2'd0;
    localparam logic [1:0] ACT_SELECT = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_WRONG = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [2:0] REG_LEVELS  = 3'd0;
    localparam logic [2:0] REG_QUANTUM = 3'd1;
    localparam logic [2:0] REG_BOOST   = 3'd2;
    localparam logic [2:0] REG_PREEMPT = 3'd3;
    localparam logic [2:0] REG_BOTTOM  = 3'd4;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_HOLDER,
        SRC_STORE
    } enq_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_REPORT,
        ST_EXP,
        ST_DIV,
        ST_BST_SCAN,
        ST_BST_RD,
        ST_BST_MOVE,
        ST_BST_HOLD,
        ST_PRE,
        ST_PICK,
        ST_PICK_RD,
        ST_PICK_LD,
        ST_PICK_WT,
        ST_PICK_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic            accept;
        logic            enq;
        logic [LvlW-1:0] enq_lvl;
        enq_src_t        enq_src;
        logic            drop;
        logic            set_cur;
        logic [LvlW-1:0] cur_lvl;
        logic            hold_clear;
        logic            pick_load;
        logic            lvl_load;
        logic            boost_hold;
        logic            tick;
        logic            div_step;
        logic            set_err_wrong;
        logic            set_err_full;
        logic            set_exp;
        logic            set_boost;
        logic            set_pre;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           action;
        logic                 fin;
        logic                 holder_valid;
        logic [LvlW-1:0]      holder_lvl;
        logic [3:0]           n_levels;
        logic [MaxLevels-1:0] full;
        logic [MaxLevels-1:0] nz;
        logic                 expire;
        logic [LvlW-1:0]      to_lvl;
        logic                 div_done;
        logic                 boost_hit;
        logic                 best_valid;
        logic [LvlW-1:0]      best_lvl;
        logic                 preempt;
        logic                 report_ok;
    } status_t;

endpackage
`default_nettype wire

### rtl/mlfq_ctrl.sv
// Sequencer for admit, select and report requests of the scheduler.
// Depends on mlfq_pkg; drives mlfq_datapath through cmd_t, reads status_t.
`default_nettype none
module mlfq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [1:0]      in_action,
    output logic                 in_ready,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire mlfq_pkg::status_t st,
    output mlfq_pkg::cmd_t       cmd
);
    import mlfq_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] scan_reg, scan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (in_action)
                        ACT_ADMIT:  state_next = ST_ADMIT;
                        ACT_SELECT: state_next = ST_EXP;
                        ACT_REPORT: state_next = ST_REPORT;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_ADMIT:
            begin
                if (st.full[0])
                begin
                    cmd.set_err_full = 1'b1;
                end
                else
                begin
                    cmd.enq     = 1'b1;
                    cmd.enq_lvl = '0;
                    cmd.enq_src = SRC_IN;
                end
                state_next = ST_OUT;
            end
            ST_REPORT:
            begin
                if (st.report_ok)
                begin
                    cmd.tick = 1'b1;
                end
                else
                begin
                    cmd.set_err_wrong = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_EXP:
            begin
                state_next = ST_DIV;
                if (st.expire)
                begin
                    if (st.full[st.to_lvl])
                    begin
                        cmd.set_err_full = 1'b1;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        cmd.enq        = 1'b1;
                        cmd.enq_lvl    = st.to_lvl;
                        cmd.enq_src    = SRC_HOLDER;
                        cmd.set_exp    = 1'b1;
                        cmd.hold_clear = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (!st.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (st.boost_hit)
                begin
                    cmd.set_boost = 1'b1;
                    scan_next     = 4'd1;
                    state_next    = ST_BST_SCAN;
                end
                else
                begin
                    state_next = ST_PRE;
                end
            end
            ST_BST_SCAN:
            begin
                if (scan_reg >= st.n_levels)
                begin
                    state_next = ST_BST_HOLD;
                end
                else if (!st.nz[scan_reg[2:0]])
                begin
                    scan_next = scan_reg + 4'd1;
                end
                else if (st.full[0])
                begin
                    cmd.set_err_full = 1'b1;
                    state_next       = ST_OUT;
                end
                else
                begin
                    cmd.set_cur = 1'b1;
                    cmd.cur_lvl = scan_reg[2:0];
                    state_next  = ST_BST_RD;
                end
            end
            ST_BST_RD:
            begin
                state_next = ST_BST_MOVE;
            end
            ST_BST_MOVE:
            begin
                cmd.enq     = 1'b1;
                cmd.enq_lvl = '0;
                cmd.enq_src = SRC_STORE;
                cmd.drop    = 1'b1;
                state_next  = ST_BST_SCAN;
            end
            ST_BST_HOLD:
            begin
                cmd.boost_hold = 1'b1;
                state_next     = ST_PRE;
            end
            ST_PRE:
            begin
                state_next = ST_PICK;
                if (st.preempt)
                begin
                    if (st.full[st.holder_lvl])
                    begin
                        cmd.set_err_full = 1'b1;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        cmd.enq        = 1'b1;
                        cmd.enq_lvl    = st.holder_lvl;
                        cmd.enq_src    = SRC_HOLDER;
                        cmd.set_pre    = 1'b1;
                        cmd.hold_clear = 1'b1;
                    end
                end
            end
            ST_PICK:
            begin
                if (!st.holder_valid && st.best_valid)
                begin
                    cmd.set_cur = 1'b1;
                    cmd.cur_lvl = st.best_lvl;
                    state_next  = ST_PICK_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_PICK_RD:
            begin
                state_next = ST_PICK_LD;
            end
            ST_PICK_LD:
            begin
                cmd.pick_load = 1'b1;
                cmd.drop      = 1'b1;
                state_next    = ST_PICK_WT;
            end
            ST_PICK_WT:
            begin
                state_next = ST_PICK_FIN;
            end
            ST_PICK_FIN:
            begin
                cmd.lvl_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/mlfq_datapath.sv
// Queues, level table, holder state, boost divider and result register.
// Depends on mlfq_pkg; commanded by mlfq_ctrl.
`default_nettype none
module mlfq_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mlfq_pkg::cmd_t                   cmd,
    output mlfq_pkg::status_t                     st,
    input  wire logic [1:0]                       in_action,
    input  wire logic [mlfq_pkg::InDataW-1:0]     in_data,
    input  wire logic                             cfg_we,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [63:0]                      cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [mlfq_pkg::OutDataW-1:0]         out_data
);
    import mlfq_pkg::*;

    logic [3:0]  levels_reg;
    logic [63:0] quantum_reg;
    logic [15:0] period_reg;
    logic        preempt_en_reg;
    logic        bottom_reg;

    logic [PidW-1:0] store_mem [0:MaxLevels*MaxProcs-1];
    logic [LvlW-1:0] lvl_mem   [0:MaxProcs-1];
    logic [PidW-1:0] store_rd_reg;
    logic [LvlW-1:0] lvl_rd_reg;

    logic [PidW-1:0] head_reg  [0:MaxLevels-1];
    logic [PidW-1:0] tail_reg  [0:MaxLevels-1];
    logic [CntW-1:0] count_reg [0:MaxLevels-1];

    logic [1:0]      act_reg;
    logic [PidW-1:0] pid_in_reg;
    logic            fin_reg;
    logic            cyc_nz_reg;
    logic [CycW-1:0] div_q_reg;
    logic [15:0]     rem_reg;
    logic [4:0]      div_cnt_reg;

    logic [PidW-1:0] holder_pid_reg;
    logic            holder_valid_reg;
    logic [LvlW-1:0] holder_lvl_reg;
    logic [7:0]      ticks_reg;
    logic [LvlW-1:0] cur_reg;

    logic [1:0] err_reg;
    logic       exp_reg, dem_reg, boost_reg, pre_reg;
    logic       out_valid_reg;
    logic [OutDataW-1:0] out_reg;

    logic [3:0]      n_lvl;
    logic [LvlW-1:0] nm1;
    logic [7:0]      quantum;
    logic [3:0]      up_lvl;
    logic [LvlW-1:0] to_lvl;
    logic [PidW-1:0] enq_pid;
    logic [16:0]     rem_sh;
    logic            best_valid;
    logic [LvlW-1:0] best_lvl;
    logic [MaxLevels-1:0] full, nz;

    always_comb
    begin
        if (levels_reg == 4'd0)
        begin
            n_lvl = 4'd1;
        end
        else if (levels_reg > 4'(MaxLevels))
        begin
            n_lvl = 4'(MaxLevels);
        end
        else
        begin
            n_lvl = levels_reg;
        end
        nm1     = 3'(n_lvl - 4'd1);
        quantum = quantum_reg[holder_lvl_reg*8 +: 8];
        if (quantum == 8'd0)
        begin
            quantum = 8'd1;
        end
        up_lvl = {1'b0, holder_lvl_reg} + 4'd1;
        if (bottom_reg || up_lvl >= n_lvl)
        begin
            to_lvl = nm1;
        end
        else
        begin
            to_lvl = up_lvl[2:0];
        end
        for (int i = 0; i < MaxLevels; i++)
        begin
            full[i] = (count_reg[i] == 7'(MaxProcs));
            nz[i]   = (count_reg[i] != 7'd0);
        end
        best_valid = 1'b0;
        best_lvl   = '0;
        for (int i = MaxLevels - 1; i >= 0; i--)
        begin
            if (nz[i] && 4'(i) < n_lvl)
            begin
                best_valid = 1'b1;
                best_lvl   = 3'(i);
            end
        end
        unique case (cmd.enq_src)
            SRC_IN:     enq_pid = pid_in_reg;
            SRC_HOLDER: enq_pid = holder_pid_reg;
            SRC_STORE:  enq_pid = store_rd_reg;
            default:    enq_pid = pid_in_reg;
        endcase
        rem_sh = {rem_reg, div_q_reg[CycW-1]};
    end

    always_comb
    begin
        st.action       = act_reg;
        st.fin          = fin_reg;
        st.holder_valid = holder_valid_reg;
        st.holder_lvl   = holder_lvl_reg;
        st.n_levels     = n_lvl;
        st.full         = full;
        st.nz           = nz;
        st.expire       = holder_valid_reg && (ticks_reg >= quantum);
        st.to_lvl       = to_lvl;
        st.div_done     = (div_cnt_reg == 5'd0);
        st.boost_hit    = (period_reg != 16'd0) && cyc_nz_reg && (rem_reg == 16'd0);
        st.best_valid   = best_valid;
        st.best_lvl     = best_lvl;
        st.preempt      = holder_valid_reg && preempt_en_reg && best_valid
                          && (best_lvl < holder_lvl_reg);
        st.report_ok    = holder_valid_reg && (holder_pid_reg == pid_in_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg     <= 4'd3;
            quantum_reg    <= 64'd525314;
            period_reg     <= 16'd20;
            preempt_en_reg <= 1'b1;
            bottom_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEVELS:  levels_reg     <= cfg_data[3:0];
                REG_QUANTUM: quantum_reg    <= cfg_data;
                REG_BOOST:   period_reg     <= cfg_data[15:0];
                REG_PREEMPT: preempt_en_reg <= cfg_data[0];
                REG_BOTTOM:  bottom_reg     <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            store_mem[{cmd.enq_lvl, tail_reg[cmd.enq_lvl]}] <= enq_pid;
        end
        store_rd_reg <= store_mem[{cur_reg, head_reg[cur_reg]}];
        if (cmd.enq)
        begin
            lvl_mem[enq_pid] <= cmd.enq_lvl;
        end
        else if (cmd.boost_hold && holder_valid_reg)
        begin
            lvl_mem[holder_pid_reg] <= '0;
        end
        lvl_rd_reg <= lvl_mem[holder_pid_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg    <= in_action;
            pid_in_reg <= in_data[5:0];
            fin_reg    <= in_data[6];
            cyc_nz_reg <= (in_data[37:7] != 31'd0);
            div_q_reg  <= in_data[37:7];
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg <= {div_q_reg[CycW-2:0], 1'b0};
            if (rem_sh >= {1'b0, period_reg})
            begin
                rem_reg <= 16'(rem_sh - {1'b0, period_reg});
            end
            else
            begin
                rem_reg <= rem_sh[15:0];
            end
        end
        if (cmd.set_cur)
        begin
            cur_reg <= cmd.cur_lvl;
        end
        if (cmd.out_load)
        begin
            out_reg <= {pre_reg, boost_reg, dem_reg, exp_reg, err_reg,
                        holder_valid_reg ? holder_lvl_reg : 3'd0,
                        holder_valid_reg,
                        holder_valid_reg ? holder_pid_reg : 6'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxLevels; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            holder_pid_reg   <= '0;
            holder_valid_reg <= 1'b0;
            holder_lvl_reg   <= '0;
            ticks_reg        <= '0;
            div_cnt_reg      <= '0;
            err_reg          <= ERR_OK;
            exp_reg          <= 1'b0;
            dem_reg          <= 1'b0;
            boost_reg        <= 1'b0;
            pre_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                div_cnt_reg <= 5'(CycW);
                err_reg     <= ERR_OK;
                exp_reg     <= 1'b0;
                dem_reg     <= 1'b0;
                boost_reg   <= 1'b0;
                pre_reg     <= 1'b0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            if (cmd.set_err_wrong)
            begin
                err_reg <= ERR_WRONG;
            end
            if (cmd.set_err_full)
            begin
                err_reg <= ERR_FULL;
            end
            if (cmd.set_exp)
            begin
                exp_reg <= 1'b1;
                dem_reg <= (to_lvl != holder_lvl_reg);
            end
            if (cmd.set_boost)
            begin
                boost_reg <= 1'b1;
            end
            if (cmd.set_pre)
            begin
                pre_reg <= 1'b1;
            end
            if (cmd.enq)
            begin
                tail_reg[cmd.enq_lvl]  <= tail_reg[cmd.enq_lvl] + 6'd1;
                count_reg[cmd.enq_lvl] <= count_reg[cmd.enq_lvl] + 7'd1;
                if (enq_pid == holder_pid_reg)
                begin
                    holder_lvl_reg <= cmd.enq_lvl;
                end
            end
            if (cmd.drop)
            begin
                head_reg[cur_reg]  <= head_reg[cur_reg] + 6'd1;
                count_reg[cur_reg] <= count_reg[cur_reg] - 7'd1;
            end
            if (cmd.hold_clear)
            begin
                holder_valid_reg <= 1'b0;
                ticks_reg        <= '0;
            end
            if (cmd.boost_hold && holder_valid_reg && holder_lvl_reg != 3'd0)
            begin
                holder_lvl_reg <= '0;
                ticks_reg      <= '0;
            end
            if (cmd.pick_load)
            begin
                holder_pid_reg   <= store_rd_reg;
                holder_valid_reg <= 1'b1;
                ticks_reg        <= '0;
            end
            if (cmd.lvl_load)
            begin
                holder_lvl_reg <= lvl_rd_reg;
            end
            if (cmd.tick)
            begin
                if (fin_reg)
                begin
                    holder_valid_reg <= 1'b0;
                    ticks_reg        <= '0;
                end
                else if (ticks_reg != 8'hFF)
                begin
                    ticks_reg <= ticks_reg + 8'd1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

### rtl/mlfq_cpu_scheduler.sv
// Requests are handled one at a time; a select passes through the 31-step boost
// remainder unit and drains boosted entries one by one through the queue memory.
// Reset: asynchronous, active low; queues empty, CPU idle, registers at defaults.
// Top level; instantiates mlfq_ctrl and mlfq_datapath, uses mlfq_pkg.
`default_nettype none
module mlfq_cpu_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // proc_id, finished, cycle_number, zero pad
    input  wire logic [1:0]  s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // chosen_pid, cpu_busy, chosen_level,
                                            // error_code, expired, demoted, boosted, preempted
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import mlfq_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    mlfq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_action (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
